[design/lkvc_pkg.sv]
// Shared types and sizing constants for the LRU key-value cache.
// No dependencies; imported by lkvc_cell, lru_key_value_cache_unit and tb_top.
package lkvc_pkg;

    localparam int unsigned ENTRIES    = 16;
    localparam int unsigned KEY_BITS   = 32;
    localparam int unsigned VALUE_BITS = 32;
    localparam int unsigned CAP_BITS   = 5;

    // Reset value of the capacity register
    localparam logic [CAP_BITS-1:0] CAP_RESET = CAP_BITS'(16);

    // Operation codes carried on s_tuser
    localparam logic OP_GET = 1'b0;
    localparam logic OP_SET = 1'b1;

    // One stored entry
    typedef struct packed {
        logic                  valid;
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] value;
    } entry_t;

    // Per-cell control from the sequencer
    typedef struct packed {
        logic cmp_en;
        logic load;
        logic evict;
    } cell_ctrl_t;

    // Sequencer states, one-hot
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_CMP  = 3'b010,
        ST_UPD  = 3'b100
    } seq_state_t;

endpackage

[design/lkvc_cell.sv]
// One slot of the recency-ordered chain: holds an entry, compares its key
// and takes its neighbor's entry on a shift. Depends on lkvc_pkg.
module lkvc_cell (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  lkvc_pkg::cell_ctrl_t             ctrl,
    input  lkvc_pkg::entry_t                 prev,
    input  logic [lkvc_pkg::KEY_BITS-1:0]    cmp_key,
    output lkvc_pkg::entry_t                 entry,
    output logic                             match
);
    import lkvc_pkg::*;

    logic                  valid_reg;
    logic [KEY_BITS-1:0]   key_reg;
    logic [VALUE_BITS-1:0] value_reg;
    logic                  match_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            match_reg <= 1'b0;
        end else begin
            if (ctrl.evict) begin
                valid_reg <= 1'b0;
            end else if (ctrl.load) begin
                valid_reg <= prev.valid;
            end
            if (ctrl.cmp_en) begin
                match_reg <= valid_reg && (key_reg == cmp_key);
            end
        end
    end

    // Payload: shift in from the neighbor
    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            key_reg   <= prev.key;
            value_reg <= prev.value;
        end
    end

    assign entry = '{valid: valid_reg, key: key_reg, value: value_reg};
    assign match = match_reg;

endmodule

[design/lru_key_value_cache_unit.sv]
// Top level of the fully associative LRU key-value cache.
// Depends on lkvc_pkg and lkvc_cell.
//
// Usage:
//   Input stream (s_*): one operation per transfer. s_tuser is the kind
//   (0 get, 1 set); s_tdata carries lookup_key in [31:0] and write_value in
//   [63:32]. Output stream (m_*): one result per operation, in order.
//   m_tuser is hit (key present before the operation); m_tdata is the
//   stored value on a get hit and zero otherwise.
//   Configuration (cfg_*): a transfer writes capacity_in_use (5 bits).
//   Values above the entry count act as the entry count. Write it only
//   while no operation is in flight.
// Timing:
//   An operation has a compare state, in which all cells compare their key
//   in parallel, then an update state, in which the chain shifts by one slot
//   on a hit or a set miss and the result is registered. A new operation is
//   accepted while idle or in the update state of the previous one, so its
//   compare overlaps the output of the previous result.
// Reset (aresetn low, synchronous): empties the store, capacity back to 16.
// Stall: the result register holds while m_tready is low; one further
//   operation may be accepted and compared, then it waits in update.
module lru_key_value_cache_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Configuration write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [lkvc_pkg::CAP_BITS-1:0]       cfg_data,   // capacity_in_use
    // Operation input
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic                                s_tuser,    // [0] kind
    input  logic [63:0]                         s_tdata,    // [31:0] lookup_key,
                                                            // [63:32] write_value
    // Result output
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic                                m_tuser,    // [0] hit
    output logic [31:0]                         m_tdata     // [31:0] read_value
);
    import lkvc_pkg::*;

    seq_state_t            state_reg, state_next;
    logic [CAP_BITS-1:0]   capacity_reg;
    logic                  kind_reg;
    logic [KEY_BITS-1:0]   key_reg;
    logic [VALUE_BITS-1:0] wval_reg;
    logic                  m_tvalid_reg;
    logic                  hit_reg;
    logic [VALUE_BITS-1:0] rdata_reg;

    entry_t                cell_entry [ENTRIES];
    cell_ctrl_t            cell_ctrl  [ENTRIES];
    logic [ENTRIES-1:0]    match_vec;
    logic [ENTRIES-1:0]    valid_vec;

    logic                  out_free;
    logic                  upd_go;
    logic                  in_xfer;
    logic                  hit;
    logic                  set_miss;
    logic [VALUE_BITS-1:0] hit_value;
    entry_t                new_entry;

    // Configuration is always accepted
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg <= CAP_RESET;
        end else if (cfg_valid && cfg_ready) begin
            capacity_reg <= cfg_data;
        end
    end

    // Sequencer: compare, then update once the output register is free
    assign out_free = !m_tvalid_reg || m_tready;
    assign upd_go   = (state_reg == ST_UPD) && out_free;
    assign s_tready = (state_reg == ST_IDLE) || upd_go;
    assign in_xfer  = s_tvalid && s_tready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_xfer) state_next = ST_CMP;
            end
            ST_CMP: begin
                state_next = ST_UPD;
            end
            ST_UPD: begin
                if (upd_go) state_next = in_xfer ? ST_CMP : ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Hold the accepted operation for the compare and update cycles
    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            kind_reg <= s_tuser;
            key_reg  <= s_tdata[KEY_BITS-1:0];
            wval_reg <= s_tdata[KEY_BITS +: VALUE_BITS];
        end
    end

    // Keys are unique, so at most one match: select its value by AND-OR
    always_comb begin
        hit_value = '0;
        for (int j = 0; j < ENTRIES; j++) begin
            hit_value = hit_value | (match_vec[j] ? cell_entry[j].value : '0);
        end
    end

    assign hit      = |match_vec;
    assign set_miss = !hit && (kind_reg == OP_SET);

    // The pair that enters slot 0 (most recent)
    assign new_entry = '{valid: 1'b1, key: key_reg,
                         value: (kind_reg == OP_SET) ? wval_reg : hit_value};

    // Chain of cells; slot 0 is most recent, valid slots are contiguous
    for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
        localparam int unsigned CELL_IDX = i;
        logic shift_here;

        if (i == 0) begin : g_head
            // Slot 0 always takes the new pair on a hit or a set miss
            assign shift_here = hit || set_miss;
        end else begin : g_body
            // Hit: shift slots up to the matching one.
            // Set miss: shift every slot up to the first empty one (or all).
            assign shift_here = hit ? (|match_vec[ENTRIES-1:i])
                                    : (set_miss && cell_entry[i-1].valid);
        end

        always_comb begin
            cell_ctrl[i].cmp_en = (state_reg == ST_CMP);
            cell_ctrl[i].load   = upd_go && shift_here;
            // Drop slots at or beyond capacity after an insert
            cell_ctrl[i].evict  = upd_go && set_miss &&
                                  (CELL_IDX >= int'(capacity_reg));
        end

        lkvc_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctrl    (cell_ctrl[i]),
            .prev    ((i == 0) ? new_entry : cell_entry[(i == 0) ? 0 : i-1]),
            .cmp_key (key_reg),
            .entry   (cell_entry[i]),
            .match   (match_vec[i])
        );

        assign valid_vec[i] = cell_entry[i].valid;
    end

    // Result register: hold while the receiver stalls
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (upd_go) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (upd_go) begin
            hit_reg   <= hit;
            rdata_reg <= (hit && (kind_reg == OP_GET)) ? hit_value : '0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = hit_reg;
    assign m_tdata  = rdata_reg;

`ifndef SYNTHESIS
    // Keys stay unique across the chain
    a_match_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(match_vec))
        else $error("more than one cell matched the key");

    // Valid slots fill from slot 0 without gaps
    a_valid_packed: assert property (@(posedge aclk) disable iff (!aresetn)
        ((valid_vec & (valid_vec + 1'b1)) == '0))
        else $error("gap in valid slots");

    // A result appears only out of the update cycle
    a_result_from_upd: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == ST_UPD))
        else $error("result raised outside update");
`endif

endmodule

[sim/tb_top.sv]
`timescale 1ns / 100ps
// Self-checking bench for lru_key_value_cache_unit: streams get/set operations,
// mirrors the recency-ordered store in a local predictor and checks every result.
// Depends on lkvc_pkg and the design sources only.
module tb_top;

    import lkvc_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 400;

    typedef struct packed {
        logic                  kind;
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] value;
    } cache_op_t;

    typedef struct packed {
        logic                  hit;
        logic [VALUE_BITS-1:0] read_value;
    } cache_result_t;

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [CAP_BITS-1:0] cfg_data  = '0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic                s_tuser   = 1'b0;
    logic [63:0]         s_tdata   = '0;
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic                m_tuser;
    logic [31:0]         m_tdata;

    // Mirror of the store: slot 0 is the most recent entry
    logic                  mirror_valid [ENTRIES];
    logic [KEY_BITS-1:0]   mirror_key   [ENTRIES];
    logic [VALUE_BITS-1:0] mirror_value [ENTRIES];
    int unsigned           mirror_count    = 0;
    logic [CAP_BITS-1:0]   mirror_capacity = CAP_RESET;

    cache_op_t     pending_ops[$];
    cache_result_t expected_results[$];
    cache_op_t     drv_op;
    cache_result_t want;

    int  ops_queued    = 0;
    int  ops_accepted  = 0;
    int  mismatches    = 0;
    int  idle_cycles   = 0;
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    int  hold_left     = 0;
    bit  hold_request  = 1'b0;
    bit  hold_served   = 1'b0;
    bit  s_taken       = 1'b0;

    lru_key_value_cache_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tuser   (m_tuser),
        .m_tdata   (m_tdata)
    );

    always #5 aclk = ~aclk;

    initial begin
        for (int i = 0; i < ENTRIES; i++) begin
            mirror_valid[i] = 1'b0;
            mirror_key[i]   = '0;
            mirror_value[i] = '0;
        end
    end

    // Rotate slots 0..pos down by one and place the pair in slot 0.
    function automatic void move_to_front(int unsigned pos, logic [KEY_BITS-1:0] key,
                                          logic [VALUE_BITS-1:0] value);
        for (int unsigned i = pos; i > 0; i--) begin
            mirror_key[i]   = mirror_key[i-1];
            mirror_value[i] = mirror_value[i-1];
            mirror_valid[i] = mirror_valid[i-1];
        end
        mirror_key[0]   = key;
        mirror_value[0] = value;
        mirror_valid[0] = 1'b1;
    endfunction

    // Apply one operation to the mirror and return the result it must produce.
    function automatic cache_result_t lru_access(logic kind, logic [KEY_BITS-1:0] key,
                                                 logic [VALUE_BITS-1:0] wval);
        cache_result_t res;
        int            found;
        int unsigned   cap;
        int unsigned   last;
        res   = '0;
        found = -1;
        for (int i = 0; i < ENTRIES; i++) begin
            if (found < 0 && mirror_valid[i] && mirror_key[i] == key)
                found = i;
        end
        if (found >= 0) begin
            res.hit = 1'b1;
            if (kind == OP_GET) begin
                res.read_value = mirror_value[found];
                move_to_front(found, key, mirror_value[found]);
            end else begin
                move_to_front(found, key, wval);
            end
        end else if (kind == OP_SET) begin
            // Insert as most recent, then evict down to the saturated capacity
            cap  = (mirror_capacity > ENTRIES) ? ENTRIES : mirror_capacity;
            last = (mirror_count < ENTRIES) ? mirror_count : ENTRIES - 1;
            move_to_front(last, key, wval);
            if (mirror_count < ENTRIES)
                mirror_count++;
            while (mirror_count > cap) begin
                mirror_count--;
                mirror_valid[mirror_count] = 1'b0;
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] exp_val);
        mismatches++;
        $display("%0t: %s mismatch, got %h, expected %h", $time, what, got, exp_val);
    endtask

    // Driver: present the next pending operation once the current one is transferred.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_taken) begin
            if (pending_ops.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                drv_op = pending_ops.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= drv_op.kind;
                s_tdata  <= {drv_op.value, drv_op.key};
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off to back up the pipeline.
    always @(negedge aclk) begin
        if (hold_request && !hold_served) begin
            hold_left   = HOLD_CYCLES;
            hold_served = 1'b1;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Monitor: check results, predict on input transfers, track config writes.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result", m_tdata, '0);
                end else begin
                    want = expected_results.pop_front();
                    if (m_tuser !== want.hit)
                        report_mismatch("hit", 32'(m_tuser), 32'(want.hit));
                    if (m_tdata !== want.read_value)
                        report_mismatch("read_value", m_tdata, want.read_value);
                end
            end
            if (s_tvalid && s_tready) begin
                expected_results.push_back(lru_access(s_tuser, s_tdata[31:0], s_tdata[63:32]));
                ops_accepted++;
            end
            if (cfg_valid && cfg_ready)
                mirror_capacity = cfg_data;
            if ((m_tvalid && m_tready) || (s_tvalid && s_tready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
        s_taken <= aresetn && s_tvalid && s_tready;
    end

    task automatic queue_op(input logic kind, input logic [31:0] key, input logic [31:0] value);
        cache_op_t op;
        op.kind  = kind;
        op.key   = key;
        op.value = value;
        pending_ops.push_back(op);
        ops_queued++;
    endtask

    // Wait until every operation is transferred and answered, then let the pipe drain.
    task automatic wait_drained();
        while (ops_accepted != ops_queued || expected_results.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_capacity(input logic [CAP_BITS-1:0] cap);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= cap;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Mostly gets and sets over a small key set so hits, moves and evictions
    // dominate; the rest is random keys that almost always miss.
    task automatic queue_random_phase(input int count, input int pool_size);
        logic [31:0] key_pool[$];
        int          pick;
        for (int i = 0; i < pool_size; i++)
            key_pool.push_back($urandom);
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(99);
            if (pick < 45)
                queue_op(OP_SET, key_pool[$urandom_range(pool_size - 1)], $urandom);
            else if (pick < 90)
                queue_op(OP_GET, key_pool[$urandom_range(pool_size - 1)], $urandom);
            else
                queue_op($urandom_range(1) ? OP_SET : OP_GET, $urandom, $urandom);
        end
    endtask

    task automatic run_phase(input logic [CAP_BITS-1:0] cap, input int s_idle,
                             input int m_stall, input int count);
        write_capacity(cap);
        send_idle_pct  = s_idle;
        recv_stall_pct = m_stall;
        queue_random_phase(count, int'((cap > ENTRIES ? ENTRIES : cap) + 4));
        wait_drained();
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // Directed: empty store, key and value extremes, overwrite, ignored get data
        write_capacity(5'd16);
        queue_op(OP_GET, 32'h0000_0000, 32'h0000_0000);
        queue_op(OP_SET, 32'h0000_0000, 32'h0000_0000);
        queue_op(OP_SET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_op(OP_GET, 32'hFFFF_FFFF, 32'h0000_0000);
        queue_op(OP_GET, 32'h0000_0000, 32'hFFFF_FFFF);
        queue_op(OP_SET, 32'h0000_0000, 32'hA5A5_5A5A);
        queue_op(OP_GET, 32'h0000_0000, 32'h0000_0000);
        queue_op(OP_GET, 32'h1234_5678, 32'hDEAD_BEEF);
        wait_drained();

        // Full store at a small capacity: a set miss drops the least recent entry
        write_capacity(5'd2);
        queue_op(OP_SET, 32'h0000_0003, 32'h0000_0033);
        queue_op(OP_GET, 32'hFFFF_FFFF, 32'h0000_0000);
        queue_op(OP_GET, 32'h0000_0000, 32'h0000_0000);
        wait_drained();

        // Capacity below occupancy: gets and set hits keep everything, a set miss trims to capacity
        write_capacity(5'd1);
        queue_op(OP_GET, 32'h0000_0003, 32'h0000_0000);
        queue_op(OP_SET, 32'h0000_0000, 32'h0000_0077);
        queue_op(OP_GET, 32'h0000_0003, 32'h0000_0000);
        queue_op(OP_SET, 32'h0000_0007, 32'h0000_0070);
        queue_op(OP_GET, 32'h0000_0003, 32'h0000_0000);
        wait_drained();

        // Zero capacity: an insert is evicted at once
        write_capacity(5'd0);
        queue_op(OP_SET, 32'h0000_0009, 32'h0000_0099);
        queue_op(OP_GET, 32'h0000_0009, 32'h0000_0000);
        queue_op(OP_GET, 32'h0000_0007, 32'h0000_0000);
        wait_drained();

        // Random phases; the first one also carries the long receiver hold-off
        hold_request = 1'b1;
        run_phase(5'd31, 0,  0,  205);
        run_phase(5'd16, 75, 0,  205);
        run_phase(5'd5,  0,  75, 205);
        run_phase(5'd1,  13, 13, 205);
        run_phase(5'd0,  0,  0,  90);
        run_phase(5'd17, 75, 0,  205);
        run_phase(5'd8,  0,  75, 205);
        run_phase(5'd3,  13, 13, 205);

        repeat (8) @(posedge aclk);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

[lru_key_value_cache_unit.f]
design/lkvc_pkg.sv
design/lkvc_cell.sv
design/lru_key_value_cache_unit.sv
sim/tb_top.sv
